// ===== sv/irr_pkg.sv =====
`timescale 1ns / 1ps

package irr_pkg;

   // Units that have base/size registers
   localparam int CFG_UNITS = 2;
   localparam int ISA_LINES = 16;
   localparam int ISA_W     = 4;

   typedef enum logic [1:0] {
      KIND_CONFIGURE = 2'd0,
      KIND_UNMASK    = 2'd1,
      KIND_MASK      = 2'd2,
      KIND_ISA_WRITE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NO_UNIT      = 3'd1,
      ST_ENABLED      = 3'd2,
      ST_BAD_FLAGS    = 3'd3,
      ST_ISA_UNMAPPED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_UNIT_COUNT = 3'd0,
      CSR_UNIT0_BASE = 3'd1,
      CSR_UNIT0_SIZE = 3'd2,
      CSR_UNIT1_BASE = 3'd3,
      CSR_UNIT1_SIZE = 3'd4
   } csr_index_type;

   localparam logic [15:0] FLAGS_DEFAULT = 16'h0000;
   localparam logic [15:0] FLAGS_ACTIVE  = 16'h0005;

   localparam logic [4:0] SIZE_RESET  = 5'd24;
   localparam logic [7:0] BASE1_RESET = 8'd24;

   typedef struct packed {
      logic [1:0]                unit_count;
      logic [CFG_UNITS-1:0][7:0] base;
      logic [CFG_UNITS-1:0][4:0] size;
   } cfg_type;

   // One redirection entry
   typedef struct packed {
      logic [7:0] vector;
      logic [2:0] deliv_mode;
      logic       masked;
      logic [7:0] destination;
   } rte_type;

   localparam rte_type RTE_RESET = '{vector: 8'h00, deliv_mode: 3'd0, masked: 1'b1,
                                     destination: 8'h00};

   // Result of the line lookup
   typedef struct packed {
      logic       hit;
      status_type status;
   } lookup_type;

endpackage

// ===== sv/irr_lookup.sv =====
`timescale 1ns / 1ps

module irr_lookup #(
   parameter int UNIT_COUNT_MAX   = 2,
   parameter int ENTRIES_PER_UNIT = 24,
   parameter int IDX_W            = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  irr_pkg::cfg_type    cfg,
   input  irr_pkg::kind_type   kind,
   input  logic                use_isa,
   input  logic [7:0]          line,
   input  logic [7:0]          target_line,
   input  logic [15:0]         override_flags,
   input  logic                route_we,
   output irr_pkg::lookup_type result,
   output logic [IDX_W-1:0]    idx
);
   import irr_pkg::*;

   logic [ISA_LINES-1:0][7:0] isa_route_ff;
   logic                      isa_ok;
   logic                      flags_ok;
   logic [7:0]                route;
   logic [7:0]                gline;
   logic [1:0]                unit_lim;
   logic [8:0]                size_cl;
   logic [7:0]                offset;

   assign isa_ok   = (line[7:ISA_W] == '0);
   assign flags_ok = (override_flags == FLAGS_DEFAULT) || (override_flags == FLAGS_ACTIVE);
   assign route    = isa_route_ff[line[ISA_W-1:0]];
   assign gline    = use_isa ? route : line;
   assign unit_lim = (32'(cfg.unit_count) > UNIT_COUNT_MAX) ? 2'(UNIT_COUNT_MAX)
                                                            : cfg.unit_count;

   always_comb begin
      result.hit    = 1'b0;
      result.status = ST_NO_UNIT;
      idx           = '0;
      size_cl       = '0;
      offset        = '0;
      // lower unit wins on overlap: scan downward, last hit sticks
      for (int u = CFG_UNITS - 1; u >= 0; u--) begin
         size_cl = (32'(cfg.size[u]) > ENTRIES_PER_UNIT) ? 9'(ENTRIES_PER_UNIT)
                                                         : {4'b0, cfg.size[u]};
         offset  = gline - cfg.base[u];
         if ((u < UNIT_COUNT_MAX) && (2'(u) < unit_lim) && (gline >= cfg.base[u]) &&
             ({1'b0, gline} < ({1'b0, cfg.base[u]} + size_cl))) begin
            result.hit = 1'b1;
            idx        = IDX_W'(u * ENTRIES_PER_UNIT) + IDX_W'(offset);
         end
      end
      if (result.hit) begin
         result.status = ST_OK;
      end
      if (kind == KIND_ISA_WRITE) begin
         result.hit = 1'b0;
         if (!isa_ok) begin
            result.status = ST_ISA_UNMAPPED;
         end else if (!flags_ok) begin
            result.status = ST_BAD_FLAGS;
         end else begin
            result.status = ST_OK;
         end
      end else if (use_isa && (!isa_ok || route == 8'h00)) begin
         result.hit    = 1'b0;
         result.status = ST_ISA_UNMAPPED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ISA_LINES; i++) begin
            isa_route_ff[i] <= 8'(i);
         end
      end else if (route_we && kind == KIND_ISA_WRITE && isa_ok && flags_ok) begin
         isa_route_ff[line[ISA_W-1:0]] <= target_line;
      end
   end

endmodule

// ===== sv/irr_rte_mem.sv =====
`timescale 1ns / 1ps

module irr_rte_mem #(
   parameter int DEPTH = 48,
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  irr_pkg::rte_type    wr_data,
   output irr_pkg::rte_type    rd_data
);
   import irr_pkg::*;

   rte_type          mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   rte_type          rd_data_ff;

   // entries never written read back as the reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // write-through bypass for a read of the entry being written
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_idx == rd_idx) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_idx]) begin
            rd_data_ff <= mem[rd_idx];
         end else begin
            rd_data_ff <= RTE_RESET;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/interrupt_redirection_router_core.sv =====
`timescale 1ns / 1ps

// Interrupt redirection router: an I/O APIC style redirection table behind a
// request stream. Each request names a global interrupt line, or an ISA line
// that first goes through a 16-entry override map; the first present unit whose
// base/size range holds the line is selected and its entry is configured (left
// masked; an already unmasked entry is left alone), unmasked or masked, or the
// request rewrites an ISA override. One response per request, in order.
// Throughput is one request per clock while responses are not stalled; a response
// passes the input register, the registered entry read, and the response register.
// Back-to-back requests to the same entry see each other's updates through a
// write-through bypass on the memory read. The entry memory needs no clearing
// pass after reset: per-entry valid bits make unwritten entries read masked.
// The csr port is always ready; write it only while no request is in flight.

module interrupt_redirection_router_core #(
   parameter int UNIT_COUNT_MAX   = 2,
   parameter int ENTRIES_PER_UNIT = 24
) (
   input  logic        clock,
   input  logic        reset,

   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] line, [15:8] vector, [18:16] deliv_mode, [26:19] destination,
   // [34:27] target_line, [50:35] override_flags, [55:51] zero
   input  logic [55:0] req_tdata,
   // [1:0] kind, [2] use_isa
   input  logic [2:0]  req_tuser,

   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [10:3] entry_vector, [13:11] entry_deliv_mode,
   // [14] entry_masked, [22:15] entry_destination, [23] zero
   output logic [23:0] rsp_tdata,

   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import irr_pkg::*;

   localparam int TOTAL = UNIT_COUNT_MAX * ENTRIES_PER_UNIT;
   localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

   // ---------------- configuration registers ----------------
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unit_count <= '0;
         cfg_ff.base[0]    <= '0;
         cfg_ff.size[0]    <= SIZE_RESET;
         cfg_ff.base[1]    <= BASE1_RESET;
         cfg_ff.size[1]    <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_UNIT_COUNT: cfg_ff.unit_count <= csr_data[1:0];
            CSR_UNIT0_BASE: cfg_ff.base[0]    <= csr_data;
            CSR_UNIT0_SIZE: cfg_ff.size[0]    <= csr_data[4:0];
            CSR_UNIT1_BASE: cfg_ff.base[1]    <= csr_data;
            CSR_UNIT1_SIZE: cfg_ff.size[1]    <= csr_data[4:0];
            default: ;  // writes beyond the list are dropped
         endcase
      end
   end

   // ---------------- handshake / pipeline control ----------------
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic out_free, s2_free, s1_free;
   logic s1_adv, s2_adv;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s2_adv     = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_valid_ff  <= req_tvalid;
         if (s2_free)  s2_valid_ff  <= s1_valid_ff;
         if (out_free) out_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   kind_type    s1_kind_ff;
   logic        s1_use_isa_ff;
   logic [7:0]  s1_line_ff, s1_vector_ff, s1_dest_ff, s1_target_ff;
   logic [2:0]  s1_mode_ff;
   logic [15:0] s1_flags_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff    <= kind_type'(req_tuser[1:0]);
         s1_use_isa_ff <= req_tuser[2];
         s1_line_ff    <= req_tdata[7:0];
         s1_vector_ff  <= req_tdata[15:8];
         s1_mode_ff    <= req_tdata[18:16];
         s1_dest_ff    <= req_tdata[26:19];
         s1_target_ff  <= req_tdata[34:27];
         s1_flags_ff   <= req_tdata[50:35];
      end
   end

   // line resolve, ISA map, unit range compare
   lookup_type       s1_look;
   logic [IDX_W-1:0] s1_idx;

   irr_lookup #(
      .UNIT_COUNT_MAX   (UNIT_COUNT_MAX),
      .ENTRIES_PER_UNIT (ENTRIES_PER_UNIT),
      .IDX_W            (IDX_W)
   ) u_lookup (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .kind           (s1_kind_ff),
      .use_isa        (s1_use_isa_ff),
      .line           (s1_line_ff),
      .target_line    (s1_target_ff),
      .override_flags (s1_flags_ff),
      .route_we       (s1_adv),
      .result         (s1_look),
      .idx            (s1_idx)
   );

   // ---------------- stage 2: entry read ----------------
   kind_type         s2_kind_ff;
   lookup_type       s2_look_ff;
   logic [IDX_W-1:0] s2_idx_ff;
   logic [7:0]       s2_vector_ff, s2_dest_ff;
   logic [2:0]       s2_mode_ff;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_kind_ff   <= s1_kind_ff;
         s2_look_ff   <= s1_look;
         s2_idx_ff    <= s1_idx;
         s2_vector_ff <= s1_vector_ff;
         s2_dest_ff   <= s1_dest_ff;
         s2_mode_ff   <= s1_mode_ff;
      end
   end

   rte_type    rd_entry;
   rte_type    new_entry;
   logic       upd_we;
   status_type s2_status;
   logic       wr_en;

   assign wr_en = s2_adv && upd_we;

   irr_rte_mem #(
      .DEPTH (TOTAL),
      .IDX_W (IDX_W)
   ) u_rte_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (s1_adv),
      .rd_idx  (s1_idx),
      .wr_en   (wr_en),
      .wr_idx  (s2_idx_ff),
      .wr_data (new_entry),
      .rd_data (rd_entry)
   );

   // entry update
   always_comb begin
      new_entry = rd_entry;
      upd_we    = 1'b0;
      s2_status = s2_look_ff.status;
      if (s2_look_ff.hit) begin
         case (s2_kind_ff)
            KIND_CONFIGURE: begin
               if (!rd_entry.masked) begin
                  s2_status = ST_ENABLED;  // entry live: leave it alone
               end else begin
                  new_entry.vector      = s2_vector_ff;
                  new_entry.deliv_mode  = s2_mode_ff;
                  new_entry.destination = s2_dest_ff;
                  new_entry.masked      = 1'b1;
                  upd_we                = 1'b1;
               end
            end
            KIND_UNMASK: begin
               new_entry.masked = 1'b0;
               upd_we           = 1'b1;
            end
            KIND_MASK: begin
               new_entry.masked = 1'b1;
               upd_we           = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // ---------------- response register ----------------
   status_type out_status_ff;
   rte_type    out_entry_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_status_ff <= s2_status;
         out_entry_ff  <= s2_look_ff.hit ? new_entry : '0;
      end
   end

   assign rsp_tdata = {1'b0, out_entry_ff.destination, out_entry_ff.masked,
                       out_entry_ff.deliv_mode, out_entry_ff.vector, out_status_ff};

`ifndef SYNTHESIS
   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // no entry addressed means all entry fields read zero
   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (out_status_ff == ST_NO_UNIT || out_status_ff == ST_BAD_FLAGS ||
                     out_status_ff == ST_ISA_UNMAPPED) |-> out_entry_ff == '0)
      else $error("entry fields set without an addressed entry");

   // already-enabled reports an unmasked entry; configure otherwise leaves it masked
   a_enabled_unmasked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_status_ff == ST_ENABLED |-> !out_entry_ff.masked)
      else $error("already-enabled status on a masked entry");

   // memory is written only as an item leaves the read stage
   a_write_gated: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s2_valid_ff && s2_look_ff.hit && out_free)
      else $error("entry write without a live item");

   // a held read stage keeps its entry index
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_idx_ff))
      else $error("read stage changed while stalled");
`endif

endmodule
